### hw/rtl/cde_pkg.sv
`default_nettype none

package cde_pkg;

  // Command codes carried in the cmd field
  typedef enum logic [3:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_PEEK_FRONT = 4'd4,
    CMD_PEEK_BACK  = 4'd5,
    CMD_GET        = 4'd6,
    CMD_SET        = 4'd7,
    CMD_CLEAR      = 4'd8,
    CMD_SEARCH     = 4'd9,
    CMD_REVERSE    = 4'd10
  } cmd_code_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_code_t;

  // Input item
  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] value_in;
    logic [3:0]  position;
  } cmd_item_t;

  // Result item
  typedef struct packed {
    logic [31:0] value_out;
    logic        found;
    logic [4:0]  count;
    logic        is_empty;
    logic [1:0]  status;
  } res_item_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SEARCH,
    S_REV_RD,
    S_REV_WA,
    S_REV_WB,
    S_FINISH
  } ctrl_state_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_EXEC,
    DP_READ_OUT,
    DP_SEARCH_NEXT,
    DP_SEARCH_OUT,
    DP_REV_RD,
    DP_REV_WA,
    DP_REV_WB,
    DP_FINISH_OUT
  } dp_op_t;

  // How the latched command proceeds after its first step
  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_READ,
    KIND_SEARCH,
    KIND_REVERSE
  } cmd_kind_t;

  // Status from datapath to controller
  typedef struct packed {
    cmd_kind_t kind;
    logic      out_free;
    logic      search_hit;
    logic      search_last;
    logic      rev_last;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/cde_dpath.sv
`default_nettype none

module cde_dpath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cde_pkg::dp_op_t    op,
  input  wire cde_pkg::cmd_item_t cmd_item,
  input  wire logic               res_ready,
  output logic                    res_valid,
  output cde_pkg::res_item_t      res_item,
  output cde_pkg::dp_stat_t       stat
);
  import cde_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 4) ? CW : 4;
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Element store and registered read ports
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_a;
  logic [DATA_WIDTH-1:0] rd_b;

  // Latched command
  logic [3:0]            cmd_q;
  logic [DATA_WIDTH-1:0] key_q;
  logic [3:0]            pos_q;

  // Deque state
  logic [AW-1:0] front;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;

  // Result register
  logic      out_valid;
  res_item_t res_q;

  // Combinational controls
  logic                  we;
  logic [AW-1:0]         wa;
  logic [DATA_WIDTH-1:0] wd;
  logic                  re_a;
  logic [AW-1:0]         aa;
  logic                  re_b;
  logic [AW-1:0]         ab;
  logic [AW-1:0]         front_next;
  logic [CW-1:0]         count_next;
  logic [AW-1:0]         idx_next;
  logic                  load;
  logic [DATA_WIDTH-1:0] ld_value;
  logic                  ld_found;
  status_code_t          ld_status;

  logic          full;
  logic          zero;
  logic          pos_bad;
  logic          cnt_lt2;
  logic          out_free;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_off;
  logic [AW-1:0] mirror_off;
  logic [CW-1:0] idx_p1_c;
  logic [CW-1:0] half;
  cmd_kind_t     kind;

  // Physical slot of a logical offset from the front
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  // Flags and pointer arithmetic
  assign full       = (count == DEPTH_C);
  assign zero       = (count == '0);
  assign pos_bad    = (PW'(pos_q) >= PW'(count));
  assign cnt_lt2    = (count < CW'(2));
  assign out_free   = !out_valid || res_ready;
  assign front_dec  = (front == '0) ? LAST_SLOT : front - 1'b1;
  assign front_inc  = (front == LAST_SLOT) ? '0 : front + 1'b1;
  assign cnt_m1     = count - 1'b1;
  assign last_off   = cnt_m1[AW-1:0];
  assign mirror_off = last_off - idx;
  assign idx_p1_c   = CW'(idx) + CW'(1);
  assign half       = count >> 1;

  // Command class for the controller
  always_comb begin
    case (cmd_q)
      CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        kind = zero ? KIND_SINGLE : KIND_READ;
      end
      CMD_GET:     kind = pos_bad ? KIND_SINGLE : KIND_READ;
      CMD_SEARCH:  kind = zero ? KIND_SINGLE : KIND_SEARCH;
      CMD_REVERSE: kind = cnt_lt2 ? KIND_SINGLE : KIND_REVERSE;
      default:     kind = KIND_SINGLE;
    endcase
  end

  assign stat.kind        = kind;
  assign stat.out_free    = out_free;
  assign stat.search_hit  = (rd_a == key_q);
  assign stat.search_last = (idx_p1_c == count);
  assign stat.rev_last    = (idx_p1_c == half);

  // Operation decode
  always_comb begin
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    re_a       = 1'b0;
    aa         = '0;
    re_b       = 1'b0;
    ab         = '0;
    front_next = front;
    count_next = count;
    idx_next   = idx;
    load       = 1'b0;
    ld_value   = '0;
    ld_found   = 1'b0;
    ld_status  = ST_OK;
    case (op)
      DP_EXEC: begin
        case (cmd_q)
          CMD_PUSH_FRONT: begin
            load = 1'b1;
            if (full) begin
              ld_status = ST_FULL;
            end else begin
              we         = 1'b1;
              wa         = front_dec;
              wd         = key_q;
              front_next = front_dec;
              count_next = count + 1'b1;
            end
          end
          CMD_PUSH_BACK: begin
            load = 1'b1;
            if (full) begin
              ld_status = ST_FULL;
            end else begin
              we         = 1'b1;
              wa         = slot_of(front, AW'(count));
              wd         = key_q;
              count_next = count + 1'b1;
            end
          end
          CMD_POP_FRONT, CMD_PEEK_FRONT: begin
            if (zero) begin
              load      = 1'b1;
              ld_status = ST_EMPTY;
            end else begin
              re_a = 1'b1;
              aa   = front;
              if (cmd_q == CMD_POP_FRONT) begin
                front_next = front_inc;
                count_next = cnt_m1;
              end
            end
          end
          CMD_POP_BACK, CMD_PEEK_BACK: begin
            if (zero) begin
              load      = 1'b1;
              ld_status = ST_EMPTY;
            end else begin
              re_a = 1'b1;
              aa   = slot_of(front, last_off);
              if (cmd_q == CMD_POP_BACK) begin
                count_next = cnt_m1;
              end
            end
          end
          CMD_GET: begin
            if (pos_bad) begin
              load      = 1'b1;
              ld_status = ST_RANGE;
            end else begin
              re_a = 1'b1;
              aa   = slot_of(front, AW'(pos_q));
            end
          end
          CMD_SET: begin
            load = 1'b1;
            if (pos_bad) begin
              ld_status = ST_RANGE;
            end else begin
              we = 1'b1;
              wa = slot_of(front, AW'(pos_q));
              wd = key_q;
            end
          end
          CMD_CLEAR: begin
            load       = 1'b1;
            front_next = '0;
            count_next = '0;
          end
          CMD_SEARCH: begin
            idx_next = '0;
            if (zero) begin
              load = 1'b1;
            end else begin
              re_a = 1'b1;
              aa   = front;
            end
          end
          CMD_REVERSE: begin
            idx_next = '0;
            load     = cnt_lt2;
          end
          default: begin
            load = 1'b1;
          end
        endcase
      end
      DP_READ_OUT: begin
        load     = 1'b1;
        ld_value = rd_a;
      end
      DP_SEARCH_NEXT: begin
        re_a     = 1'b1;
        aa       = slot_of(front, idx + 1'b1);
        idx_next = idx + 1'b1;
      end
      DP_SEARCH_OUT: begin
        load     = 1'b1;
        ld_found = stat.search_hit;
      end
      DP_REV_RD: begin
        re_a = 1'b1;
        aa   = slot_of(front, idx);
        re_b = 1'b1;
        ab   = slot_of(front, mirror_off);
      end
      DP_REV_WA: begin
        we = 1'b1;
        wa = slot_of(front, idx);
        wd = rd_b;
      end
      DP_REV_WB: begin
        we       = 1'b1;
        wa       = slot_of(front, mirror_off);
        wd       = rd_a;
        idx_next = idx + 1'b1;
      end
      DP_FINISH_OUT: begin
        load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re_a) begin
      rd_a <= mem[aa];
    end
    if (re_b) begin
      rd_b <= mem[ab];
    end
  end

  // Command latch, work index and result register
  always_ff @(posedge clk) begin
    if (op == DP_LATCH) begin
      cmd_q <= cmd_item.cmd;
      key_q <= DATA_WIDTH'(cmd_item.value_in);
      pos_q <= cmd_item.position;
    end
    idx <= idx_next;
    if (load) begin
      res_q.value_out <= 32'(ld_value);
      res_q.found     <= ld_found;
      res_q.count     <= 5'(count_next);
      res_q.is_empty  <= (count_next == '0);
      res_q.status    <= ld_status;
    end
  end

  // Pointer, count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      front <= front_next;
      count <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (res_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res_valid = out_valid;
  assign res_item  = res_q;

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("result register loaded while an untaken result waits");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (count <= DEPTH_C) && ({1'b0, front} < DEPTH_W))
    else $error("count or front pointer out of range");

  a_state_change: assert property (@(posedge clk) disable iff (rst)
    ((count != $past(count)) || (front != $past(front))) |-> $past(op == DP_EXEC))
    else $error("deque state changed outside the execute step");

endmodule

`default_nettype wire

### hw/rtl/cde_ctrl.sv
`default_nettype none

module cde_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire cde_pkg::dp_stat_t stat,
  output cde_pkg::dp_op_t        op
);
  import cde_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath operation
  always_comb begin
    state_next = state;
    op         = DP_NONE;
    cmd_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          op         = DP_LATCH;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          op = DP_EXEC;
          case (stat.kind)
            KIND_READ:    state_next = S_READ;
            KIND_SEARCH:  state_next = S_SEARCH;
            KIND_REVERSE: state_next = S_REV_RD;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        if (stat.out_free) begin
          op         = DP_READ_OUT;
          state_next = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (stat.search_hit || stat.search_last) begin
          if (stat.out_free) begin
            op         = DP_SEARCH_OUT;
            state_next = S_IDLE;
          end
        end else begin
          op = DP_SEARCH_NEXT;
        end
      end
      S_REV_RD: begin
        op         = DP_REV_RD;
        state_next = S_REV_WA;
      end
      S_REV_WA: begin
        op         = DP_REV_WA;
        state_next = S_REV_WB;
      end
      S_REV_WB: begin
        op         = DP_REV_WB;
        state_next = stat.rev_last ? S_FINISH : S_REV_RD;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          op         = DP_FINISH_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/circular_deque_engine_core.sv
// Channel   Signals                              Dir  Transfer when
// command   cmd_valid, cmd_ready, cmd_item       in   cmd_valid && cmd_ready
// result    res_valid, res_ready, res_item       out  res_valid && res_ready
//
// One command at a time; each gives exactly one result.
// Push, set, clear, failing commands: latch, execute. Pop, peek, get: latch, execute,
// read-out (registered read of the element store). Search: one compare per element.
// Reverse: latch, execute, read, write, write per pair (one store write port), finish.
// Reset clears front pointer, count and result valid; store needs no sweep.
// An untaken result stalls the execute step and the step that loads the next result.
`default_nettype none

module circular_deque_engine_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire cde_pkg::cmd_item_t cmd_item,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output cde_pkg::res_item_t      res_item
);
  import cde_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  cde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .op        (op)
  );

  cde_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cmd_item  (cmd_item),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_item  (res_item),
    .stat      (stat)
  );

endmodule

`default_nettype wire
